[sv/tlpm_pkg.sv]
// ----------------------------------------------------------------------------
// tlpm_pkg: shared types and constants of the two-level page table manager
// Command and status codes, controller states, leaf entry layout and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlpm_pkg;

  // Root and leaf tables both hold 1024 entries (10 index bits each)
  localparam int unsigned RootEntries = 1024;
  localparam int unsigned LeafEntries = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned OffsW       = 12;
  localparam int unsigned PpnW        = 20;

  typedef enum logic [1:0] {
    CMD_ASSIGN    = 2'd0,
    CMD_DEASSIGN  = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNMAPPED   = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_CLR_DONE,
    S_DECIDE,
    S_SWEEP,
    S_WRITE,
    S_LEAF
  } state_e;

  // Leaf entry: physical page number and r/w/x/valid flags
  typedef struct packed {
    logic [PpnW-1:0] ppn;
    logic            x;
    logic            w;
    logic            r;
    logic            v;
  } leaf_t;

  // Controller to datapath
  typedef struct packed {
    logic    req_ready;
    logic    cap_req;
    logic    root_clr;
    logic    root_alloc;
    logic    tbl_load;
    logic    tbl_from_root;
    logic    leaf_clr;
    logic    leaf_wr;
    logic    pool_reset;
    logic    rsp_load;
    status_e rsp_status;
    logic    rsp_addr_sel;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic req_valid;
    cmd_e req_cmd;
    cmd_e cmd;
    logic va_misaligned;
    logic pa_misaligned;
    logic root_valid;
    logic pool_empty;
    logic leaf_valid;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

[sv/tlpm_if.sv]
// ----------------------------------------------------------------------------
// tlpm_if: request and response channels of the page table manager
// Valid/ready channels; a request or response moves when both are high.
// ----------------------------------------------------------------------------
interface tlpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] vaddr;
  logic [31:0] paddr;
  logic        perm_read;
  logic        perm_write;
  logic        perm_exec;

  modport source (
    output valid, command, vaddr, paddr,
    output perm_read, perm_write, perm_exec,
    input  ready
  );
  modport sink (
    input  valid, command, vaddr, paddr,
    input  perm_read, perm_write, perm_exec,
    output ready
  );
endinterface

interface tlpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] translated_address;

  modport source (output valid, status, translated_address, input ready);
  modport sink (input valid, status, translated_address, output ready);
endinterface

[sv/two_level_page_table_manager_core.sv]
// ----------------------------------------------------------------------------
// two_level_page_table_manager_core: two-level page table for 32-bit addresses
// Assign, deassign, translate and clear commands over a 1024-entry root table
// and a pool of 1024-entry leaf tables, one response per request.
// ----------------------------------------------------------------------------
// One request is handled at a time; the response register lets the next
// request in while a response waits, and a stalled response holds the
// controller only when the following response is ready to be staged. A
// translate that finds its root entry valid, and an assign or deassign on a
// page whose leaf table already exists, pass the root read, the leaf read or
// write and the response register. A request refused at the root read
// (misaligned virtual address, exhausted pool, translate with no root entry)
// skips the leaf step. An assign or deassign that takes a new leaf table first
// clears it, one entry per cycle through the single leaf memory write port.
// Clear invalidates the root table one entry per cycle. After reset the same
// root clearing pass runs, during which no request is accepted. Misaligned
// addresses and an exhausted pool come back as status codes.
module two_level_page_table_manager_core
  import tlpm_pkg::*;
#(
  parameter int unsigned LEAF_TABLES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlpm_req_if.sink   req_i,
  tlpm_rsp_if.source rsp_o
);

  ctrl_t  ctrl;
  stat_t  stat;
  state_e state;

  tlpm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .state_o (state)
  );

  tlpm_dp #(
    .LEAF_TABLES (LEAF_TABLES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // A taken request blocks the input until its response is staged
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // No request during the clearing pass after reset
  a_no_req_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_INIT) |-> !req_i.ready)
    else $error("request port open during root clearing");

  // Never overwrite an undelivered response
  a_no_rsp_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rsp_load |-> stat.out_free)
    else $error("response overwritten");

  // Address is zero unless the status is ok
  a_addr_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.translated_address == '0))
    else $error("nonzero address with error status");

endmodule

[sv/tlpm_ctrl.sv]
// ----------------------------------------------------------------------------
// tlpm_ctrl: sequencer of the page table manager
// Walks each request through root lookup, table allocation and clearing,
// leaf access and result delivery by driving datapath commands.
// ----------------------------------------------------------------------------
module tlpm_ctrl
  import tlpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stat_t  stat_i,
  output ctrl_t  ctrl_o,
  output state_e state_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.rsp_status = ST_OK;
    case (state_q)
      // Sweep the root table after reset
      S_INIT: begin
        ctrl_o.root_clr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      // Take a request and start the root read
      S_IDLE: begin
        ctrl_o.req_ready = 1'b1;
        if (stat_i.req_valid) begin
          ctrl_o.cap_req = 1'b1;
          if (stat_i.req_cmd == CMD_CLEAR) begin
            ctrl_o.pool_reset = 1'b1;
            state_d = S_CLR;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end
      // Invalidate all root entries
      S_CLR: begin
        ctrl_o.root_clr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_CLR_DONE;
        end
      end
      S_CLR_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.rsp_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      // Root entry is available
      S_DECIDE: begin
        case (stat_i.cmd)
          CMD_TRANSLATE: begin
            if (!stat_i.root_valid) begin
              ctrl_o.rsp_status = ST_UNMAPPED;
              if (stat_i.out_free) begin
                ctrl_o.rsp_load = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              ctrl_o.tbl_from_root = 1'b1;
              ctrl_o.tbl_load      = 1'b1;
              state_d = S_LEAF;
            end
          end
          CMD_ASSIGN, CMD_DEASSIGN: begin
            if (stat_i.va_misaligned) begin
              ctrl_o.rsp_status = ST_MISALIGNED;
              if (stat_i.out_free) begin
                ctrl_o.rsp_load = 1'b1;
                state_d = S_IDLE;
              end
            end else if (!stat_i.root_valid) begin
              if (stat_i.pool_empty) begin
                ctrl_o.rsp_status = ST_EXHAUSTED;
                if (stat_i.out_free) begin
                  ctrl_o.rsp_load = 1'b1;
                  state_d = S_IDLE;
                end
              end else begin
                // Take a fresh table and clear it
                ctrl_o.root_alloc = 1'b1;
                ctrl_o.tbl_load   = 1'b1;
                state_d = S_SWEEP;
              end
            end else begin
              ctrl_o.tbl_load = 1'b1;
              state_d = S_WRITE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      // Clear the newly taken leaf table
      S_SWEEP: begin
        ctrl_o.leaf_clr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_WRITE;
        end
      end
      // Update the leaf entry and report
      S_WRITE: begin
        if (stat_i.cmd == CMD_ASSIGN && stat_i.pa_misaligned) begin
          ctrl_o.rsp_status = ST_MISALIGNED;
        end
        if (stat_i.out_free) begin
          ctrl_o.rsp_load = 1'b1;
          ctrl_o.leaf_wr  = !(stat_i.cmd == CMD_ASSIGN && stat_i.pa_misaligned);
          state_d = S_IDLE;
        end
      end
      // Leaf entry is available
      S_LEAF: begin
        ctrl_o.rsp_status   = stat_i.leaf_valid ? ST_OK : ST_UNMAPPED;
        ctrl_o.rsp_addr_sel = stat_i.leaf_valid;
        if (stat_i.out_free) begin
          ctrl_o.rsp_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

[sv/tlpm_dp.sv]
// ----------------------------------------------------------------------------
// tlpm_dp: datapath of the page table manager
// Request registers, root and leaf table memories, table pool counter,
// sweep counter and the response register.
// ----------------------------------------------------------------------------
module tlpm_dp
  import tlpm_pkg::*;
#(
  parameter int unsigned LEAF_TABLES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlpm_req_if.sink      req_i,
  tlpm_rsp_if.source    rsp_o,
  input  ctrl_t         ctrl_i,
  output stat_t         stat_o
);

  localparam int unsigned TblW   = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
  localparam int unsigned CntW   = $clog2(LEAF_TABLES + 1);
  localparam int unsigned LeafAw = TblW + IdxW;
  localparam int unsigned LeafDepth = LEAF_TABLES * LeafEntries;
  localparam int unsigned RootW  = TblW + 1;

  // Captured request
  cmd_e        cmd_q;
  logic [31:0] va_q;
  logic [31:0] pa_q;
  logic        pr_q, pw_q, px_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_req) begin
      cmd_q <= cmd_e'(req_i.command);
      va_q  <= req_i.vaddr;
      pa_q  <= req_i.paddr;
      pr_q  <= req_i.perm_read;
      pw_q  <= req_i.perm_write;
      px_q  <= req_i.perm_exec;
    end
  end

  // Sweep counter, shared by root and leaf clearing (both 1024 entries)
  logic [IdxW-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctrl_i.cap_req) begin
      sweep_q <= '0;
    end else if (ctrl_i.root_clr || ctrl_i.leaf_clr) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // Table pool: tables are handed out in order
  logic [CntW-1:0] used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.pool_reset) begin
      used_q <= '0;
    end else if (ctrl_i.root_alloc) begin
      used_q <= used_q + 1'b1;
    end
  end

  // Root table: valid bit and table index
  logic [RootW-1:0] root_mem [RootEntries];
  logic [RootW-1:0] root_rd_q;
  logic [IdxW-1:0]  root_rd_addr;
  logic [IdxW-1:0]  root_wr_addr;
  logic [RootW-1:0] root_wr_data;

  assign root_rd_addr = ctrl_i.cap_req ? req_i.vaddr[31:22] : va_q[31:22];
  assign root_wr_addr = ctrl_i.root_clr ? sweep_q : va_q[31:22];
  assign root_wr_data = ctrl_i.root_clr ? '0 : {1'b1, used_q[TblW-1:0]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.root_clr || ctrl_i.root_alloc) begin
      root_mem[root_wr_addr] <= root_wr_data;
    end
    root_rd_q <= root_mem[root_rd_addr];
  end

  // Table index of the current request
  logic [TblW-1:0] tbl_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tbl_load) begin
      tbl_q <= ctrl_i.root_alloc ? used_q[TblW-1:0] : root_rd_q[TblW-1:0];
    end
  end

  // Leaf tables
  leaf_t             leaf_mem [LeafDepth];
  leaf_t             leaf_rd_q;
  leaf_t             leaf_wr_data;
  logic [LeafAw-1:0] leaf_rd_addr;
  logic [LeafAw-1:0] leaf_wr_addr;

  assign leaf_rd_addr = {ctrl_i.tbl_from_root ? root_rd_q[TblW-1:0] : tbl_q,
                         va_q[21:12]};
  assign leaf_wr_addr = {tbl_q, ctrl_i.leaf_clr ? sweep_q : va_q[21:12]};

  always_comb begin
    leaf_wr_data = '0;
    if (ctrl_i.leaf_wr && cmd_q == CMD_ASSIGN) begin
      leaf_wr_data.ppn = pa_q[31:12];
      leaf_wr_data.x   = px_q;
      leaf_wr_data.w   = pw_q;
      leaf_wr_data.r   = pr_q;
      leaf_wr_data.v   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.leaf_clr || ctrl_i.leaf_wr) begin
      leaf_mem[leaf_wr_addr] <= leaf_wr_data;
    end
    leaf_rd_q <= leaf_mem[leaf_rd_addr];
  end

  // Response register
  logic        rsp_valid_q;
  status_e     rsp_status_q;
  logic [31:0] rsp_addr_q;
  logic        out_free;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rsp_load) begin
      rsp_status_q <= ctrl_i.rsp_status;
      rsp_addr_q   <= ctrl_i.rsp_addr_sel ? {leaf_rd_q.ppn, va_q[OffsW-1:0]} : '0;
    end
  end

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.status             = rsp_status_q;
  assign rsp_o.translated_address = rsp_addr_q;
  assign req_i.ready              = ctrl_i.req_ready;

  // Status toward the controller
  assign stat_o.req_valid     = req_i.valid;
  assign stat_o.req_cmd       = cmd_e'(req_i.command);
  assign stat_o.cmd           = cmd_q;
  assign stat_o.va_misaligned = |va_q[OffsW-1:0];
  assign stat_o.pa_misaligned = |pa_q[OffsW-1:0];
  assign stat_o.root_valid    = root_rd_q[RootW-1];
  assign stat_o.pool_empty    = (used_q == CntW'(LEAF_TABLES));
  assign stat_o.leaf_valid    = leaf_rd_q.v;
  assign stat_o.sweep_last    = (sweep_q == IdxW'(LeafEntries - 1));
  assign stat_o.out_free      = out_free;

endmodule

[bench/tb_two_level_page_table_manager_core.sv]
// ----------------------------------------------------------------------------
// tb_two_level_page_table_manager_core: self-checking bench for the page table
// Drives assign, deassign, translate and clear requests with random bursts and
// gaps, stalls the response side, and checks every response against a local
// model of the root table, the leaf table pool and the pool counter.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_manager_core
  import tlpm_pkg::*;
();

  localparam int unsigned LeafTables = 64;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HotRoots   = 6;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] va;
    logic [31:0] pa;
    logic        r;
    logic        w;
    logic        x;
  } page_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
  } page_rsp_t;

  typedef struct packed {
    page_req_t req;
    page_rsp_t rsp;
  } page_expect_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlpm_req_if req_if ();
  tlpm_rsp_if rsp_if ();

  two_level_page_table_manager_core #(
    .LEAF_TABLES(LeafTables)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the page table state
  bit          mdl_root_valid [RootEntries];
  int unsigned mdl_root_table [RootEntries];
  leaf_t       mdl_leaf       [LeafTables*LeafEntries];
  int unsigned mdl_tables_used;

  page_expect_t page_rsp_q[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;

  // Apply one request to the local tables and return its response
  function automatic page_rsp_t page_table_apply(page_req_t q);
    page_rsp_t       rsp;
    logic [IdxW-1:0] ri;
    logic [IdxW-1:0] li;
    int unsigned     slot;
    int unsigned     k;
    leaf_t           e;
    rsp.status = ST_OK;
    rsp.addr   = '0;
    ri = q.va[31:22];
    li = q.va[21:12];
    case (q.cmd)
      CMD_ASSIGN, CMD_DEASSIGN: begin
        if (q.va[OffsW-1:0] != '0) begin
          rsp.status = ST_MISALIGNED;
        end else if (!mdl_root_valid[ri] && mdl_tables_used >= LeafTables) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          // take and clear the next table when the root entry is empty
          if (!mdl_root_valid[ri]) begin
            mdl_root_valid[ri] = 1'b1;
            mdl_root_table[ri] = mdl_tables_used;
            for (k = 0; k < LeafEntries; k++) begin
              mdl_leaf[mdl_tables_used*LeafEntries + k] = '0;
            end
            mdl_tables_used++;
          end
          slot = (mdl_root_table[ri] % LeafTables) * LeafEntries + li;
          if (q.cmd == CMD_DEASSIGN) begin
            mdl_leaf[slot] = '0;
          end else if (q.pa[OffsW-1:0] != '0) begin
            rsp.status = ST_MISALIGNED;
          end else begin
            e.ppn = q.pa[31:OffsW];
            e.x   = q.x;
            e.w   = q.w;
            e.r   = q.r;
            e.v   = 1'b1;
            mdl_leaf[slot] = e;
          end
        end
      end
      CMD_TRANSLATE: begin
        if (!mdl_root_valid[ri]) begin
          rsp.status = ST_UNMAPPED;
        end else begin
          e = mdl_leaf[(mdl_root_table[ri] % LeafTables) * LeafEntries + li];
          if (!e.v) begin
            rsp.status = ST_UNMAPPED;
          end else begin
            rsp.addr = {e.ppn, q.va[OffsW-1:0]};
          end
        end
      end
      default: begin
        foreach (mdl_root_valid[i]) mdl_root_valid[i] = 1'b0;
        mdl_tables_used = 0;
      end
    endcase
    return rsp;
  endfunction

  // Send one request, opening a new burst after a random gap when due
  task automatic issue_page_cmd(input cmd_e cmd, input logic [31:0] va,
                                input logic [31:0] pa, input logic [2:0] rwx);
    page_req_t    q;
    page_expect_t e;
    int unsigned  gap;
    q.cmd = cmd;
    q.va  = va;
    q.pa  = pa;
    q.r   = rwx[2];
    q.w   = rwx[1];
    q.x   = rwx[0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        req_if.valid     <= 1'b0;
        req_if.command   <= 2'($urandom_range(0, 3));
        req_if.vaddr     <= $urandom();
        req_if.paddr     <= $urandom();
        req_if.perm_read <= 1'($urandom_range(0, 1));
        @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.command    <= q.cmd;
    req_if.vaddr      <= q.va;
    req_if.paddr      <= q.pa;
    req_if.perm_read  <= q.r;
    req_if.perm_write <= q.w;
    req_if.perm_exec  <= q.x;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    e.req = q;
    e.rsp = page_table_apply(q);
    page_rsp_q.insert(page_rsp_q.size(), e);
  endtask

  // Hold off requests until every response is back
  task automatic wait_page_rsp_drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (page_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Corner pages, both table levels missing, misalignment and clear
  task automatic test_walk_corners();
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 3'b000);
    issue_page_cmd(CMD_ASSIGN,    32'h0000_0000, 32'hFFFF_F000, 3'b111);
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_0FFF, 32'hFFFF_FFFF, 3'b111);
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_1000, 32'h0, 3'b000);
    issue_page_cmd(CMD_ASSIGN,    32'hFFFF_F000, 32'h0000_0000, 3'b000);
    issue_page_cmd(CMD_TRANSLATE, 32'hFFFF_F123, 32'h0, 3'b000);
    // misaligned virtual address on an empty root takes no table
    issue_page_cmd(CMD_ASSIGN,    32'h0040_0001, 32'h1234_5000, 3'b101);
    issue_page_cmd(CMD_TRANSLATE, 32'h0040_0000, 32'h0, 3'b000);
    // misaligned physical address still takes the table
    issue_page_cmd(CMD_ASSIGN,    32'h0040_0000, 32'h1234_5678, 3'b010);
    issue_page_cmd(CMD_TRANSLATE, 32'h0040_0000, 32'h0, 3'b000);
    // deassign on an empty root takes a table too
    issue_page_cmd(CMD_DEASSIGN,  32'h0080_0000, 32'hFFFF_FFFF, 3'b111);
    issue_page_cmd(CMD_DEASSIGN,  32'h0000_0000, 32'h0, 3'b000);
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_0ABC, 32'h0, 3'b000);
    issue_page_cmd(CMD_DEASSIGN,  32'h0000_0800, 32'h0, 3'b000);
    issue_page_cmd(CMD_ASSIGN,    32'h0000_0000, 32'hABCD_E000, 3'b101);
    issue_page_cmd(CMD_ASSIGN,    32'h0000_0000, 32'h5555_5000, 3'b010);
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_0555, 32'h0, 3'b000);
    issue_page_cmd(CMD_CLEAR,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    issue_page_cmd(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 3'b000);
    issue_page_cmd(CMD_TRANSLATE, 32'hFFFF_F000, 32'h0, 3'b000);
    // the reused first table must come back cleared
    issue_page_cmd(CMD_ASSIGN,    32'hFFFF_F000, 32'h8000_0000, 3'b100);
    issue_page_cmd(CMD_TRANSLATE, 32'hFFC0_0000, 32'h0, 3'b000);
    issue_page_cmd(CMD_TRANSLATE, 32'hFFFF_F001, 32'h0, 3'b000);
    issue_page_cmd(CMD_CLEAR,     32'h0, 32'h0, 3'b000);
  endtask

  // Fill the pool with one table per root, then hit the empty pool
  task automatic test_pool_exhaustion();
    logic [IdxW-1:0] first_root;
    logic [IdxW-1:0] root;
    logic [31:0]     va;
    int unsigned     i;
    first_root = IdxW'($urandom_range(0, RootEntries-1));
    va = '0;
    issue_page_cmd(CMD_CLEAR, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
    for (i = 0; i <= LeafTables; i++) begin
      root = first_root + IdxW'(i * 37);
      va = {root, 10'($urandom_range(0, LeafEntries-1)), 12'h000};
      issue_page_cmd(CMD_ASSIGN, va, {20'($urandom()), 12'h000},
                     3'($urandom_range(0, 7)));
      issue_page_cmd(CMD_TRANSLATE, va | 32'($urandom_range(0, 4095)), $urandom(),
                     3'($urandom_range(0, 7)));
    end
    // the last root met an empty pool; misalignment is reported first
    issue_page_cmd(CMD_DEASSIGN, va, $urandom(), 3'($urandom_range(0, 7)));
    issue_page_cmd(CMD_ASSIGN, va | 32'h0000_0001, 32'h0, 3'b111);
    issue_page_cmd(CMD_ASSIGN, {first_root, 10'd5, 12'h000}, 32'hC0DE_0000, 3'b011);
    issue_page_cmd(CMD_TRANSLATE, {first_root, 10'd5, 12'hABC}, 32'h0, 3'b000);
    issue_page_cmd(CMD_CLEAR, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
  endtask

  // Mixed traffic over a few hot roots, with rare new roots and clears
  task automatic test_mixed_traffic();
    logic [IdxW-1:0] hot_root [HotRoots];
    logic [31:0]     mapped_va_q[$];
    logic [31:0]     va;
    logic [31:0]     pa;
    int unsigned     n;
    int unsigned     pick;
    foreach (hot_root[k]) hot_root[k] = IdxW'($urandom_range(0, RootEntries-1));
    for (n = 0; n < 1200; n++) begin
      if (n == 600) wait_page_rsp_drain();
      pick = $urandom_range(0, 999);
      if ($urandom_range(0, 19) == 0) begin
        va = {10'($urandom_range(0, RootEntries-1)), 10'($urandom_range(0, 1023)), 12'h0};
      end else begin
        va = {hot_root[$urandom_range(0, HotRoots-1)], 10'($urandom_range(0, 1023)),
              12'h0};
      end
      pa = $urandom();
      if ($urandom_range(0, 11) != 0) pa[OffsW-1:0] = '0;
      if (pick < 8) begin
        // refill the pool and move the hot roots
        issue_page_cmd(CMD_CLEAR, $urandom(), pa, 3'($urandom_range(0, 7)));
        foreach (hot_root[k]) hot_root[k] = IdxW'($urandom_range(0, RootEntries-1));
        mapped_va_q.delete();
      end else if (pick < 360) begin
        if ($urandom_range(0, 11) == 0) va[OffsW-1:0] = 12'($urandom_range(1, 4095));
        issue_page_cmd(CMD_ASSIGN, va, pa, 3'($urandom_range(0, 7)));
        if (va[OffsW-1:0] == '0 && pa[OffsW-1:0] == '0) begin
          mapped_va_q.insert(mapped_va_q.size(), va);
          if (mapped_va_q.size() > 48) void'(mapped_va_q.pop_front());
        end
      end else if (pick < 520) begin
        if (mapped_va_q.size() != 0 && $urandom_range(0, 1) == 0) begin
          va = mapped_va_q[$urandom_range(0, mapped_va_q.size()-1)];
        end
        if ($urandom_range(0, 11) == 0) va[OffsW-1:0] = 12'($urandom_range(1, 4095));
        issue_page_cmd(CMD_DEASSIGN, va, pa, 3'($urandom_range(0, 7)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60 && mapped_va_q.size() != 0) begin
          va = mapped_va_q[$urandom_range(0, mapped_va_q.size()-1)];
        end else if (pick >= 85) begin
          va = $urandom();
        end
        va[OffsW-1:0] = 12'($urandom_range(0, 4095));
        issue_page_cmd(CMD_TRANSLATE, va, pa, 3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Stall the response side in segments and check every response
  initial begin : rsp_side
    page_expect_t e;
    int unsigned  seg_left;
    int unsigned  ready_pct;
    rsp_if.ready = 1'b0;
    seg_left  = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (page_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("cycle %0d: response with none pending, status %0d addr %h",
                     cycle_count, rsp_if.status, rsp_if.translated_address);
          end
        end else begin
          e = page_rsp_q.pop_front();
          if (rsp_if.status !== e.rsp.status ||
              rsp_if.translated_address !== e.rsp.addr) begin
            error_count++;
            if (error_count <= 10) begin
              $display("cycle %0d: cmd %s va %h pa %h: expected status %0d addr %h, got %0d %h",
                       cycle_count, e.req.cmd.name(), e.req.va, e.req.pa, e.rsp.status,
                       e.rsp.addr, rsp_if.status, rsp_if.translated_address);
            end
          end
        end
      end
      if (seg_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin ready_pct = 100; seg_left = $urandom_range(16, 96); end
          1: begin ready_pct = 75;  seg_left = $urandom_range(16, 96); end
          2: begin ready_pct = 25;  seg_left = $urandom_range(16, 96); end
          default: begin ready_pct = 0; seg_left = $urandom_range(1, 20); end
        endcase
      end
      seg_left--;
      rsp_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_two_level_page_table_manager_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    error_count     = 0;
    burst_left      = 0;
    mdl_tables_used = 0;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_ASSIGN;
    req_if.vaddr      = '0;
    req_if.paddr      = '0;
    req_if.perm_read  = 1'b0;
    req_if.perm_write = 1'b0;
    req_if.perm_exec  = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_walk_corners();
    wait_page_rsp_drain();
    test_pool_exhaustion();
    wait_page_rsp_drain();
    test_mixed_traffic();
    wait_page_rsp_drain();
    repeat (40) @(posedge clk_i);

    if (error_count == 0 && page_rsp_q.size() == 0) begin
      $display("tb_two_level_page_table_manager_core OK");
    end else begin
      $display("tb_two_level_page_table_manager_core NOT OK");
    end
    $finish;
  end

endmodule
